// ===== src/cubic_bezier_easing_core_assert.svh =====
// assertion macros for the cubic bezier easing core
// used by the top level only, no other dependencies
`ifndef CUBIC_BEZIER_EASING_CORE_ASSERT_SVH
`define CUBIC_BEZIER_EASING_CORE_ASSERT_SVH

// same-cycle implication
`define CBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cbe_pkg.sv =====
// shared types, constants and helpers of the cubic bezier easing core
// no dependencies
package cbe_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_ITERATIONS = 12;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS);

  localparam int PROG_W     = 17;
  localparam int CTRL_X_W   = 17;
  localparam int CTRL_Y_W   = 19;
  localparam int OUT_W      = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int T_W        = 17;
  localparam int COEF_W     = 24;
  localparam int ACC_W      = 26;

  localparam logic [T_W-1:0] FX_ONE = T_W'(64'd1 << FRAC_BITS);

  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-131072);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(196608);

  localparam logic [CTRL_X_W-1:0] RST_X1 = CTRL_X_W'(16056);
  localparam logic [CTRL_Y_W-1:0] RST_Y1 = CTRL_Y_W'(6554);
  localparam logic [CTRL_X_W-1:0] RST_X2 = CTRL_X_W'(16384);
  localparam logic [CTRL_Y_W-1:0] RST_Y2 = CTRL_Y_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X1,
    CFG_Y1,
    CFG_X2,
    CFG_Y2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STEP_A,
    STEP_B,
    STEP_C
  } horner_step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XEVAL,
    ST_XCMP,
    ST_YEVAL,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic        [CTRL_X_W-1:0] x1;
    logic signed [CTRL_Y_W-1:0] y1;
    logic        [CTRL_X_W-1:0] x2;
    logic signed [CTRL_Y_W-1:0] y2;
  } ctrl_pts_t;

  typedef struct packed {
    logic         load;
    logic         run;
    logic         sel_y;
    horner_step_e step;
  } horner_ctrl_t;

  // clamp an accumulator value into the output range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    begin
      r = v;
      if (v < OUT_MIN) r = OUT_MIN;
      if (v > OUT_MAX) r = OUT_MAX;
      return OUT_W'(r);
    end
  endfunction

endpackage

// ===== src/cbe_if.sv =====
// valid/ready stream interfaces for progress in and eased value out
// depends on cbe_pkg
interface cbe_in_if import cbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROG_W-1:0] progress;

  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

interface cbe_out_if import cbe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

// ===== src/cbe_cfg_regs.sv =====
// control point registers written through the plain config port
// depends on cbe_pkg
module cbe_cfg_regs import cbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output ctrl_pts_t             pts_o
);

  ctrl_pts_t pts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q.x1 <= RST_X1;
      pts_q.y1 <= RST_Y1;
      pts_q.x2 <= RST_X2;
      pts_q.y2 <= RST_Y2;
    end else if (we_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_X1:  pts_q.x1 <= wdata_i[CTRL_X_W-1:0];
        CFG_Y1:  pts_q.y1 <= wdata_i[CTRL_Y_W-1:0];
        CFG_X2:  pts_q.x2 <= wdata_i[CTRL_X_W-1:0];
        CFG_Y2:  pts_q.y2 <= wdata_i[CTRL_Y_W-1:0];
        default: ;
      endcase
    end
  end

  assign pts_o = pts_q;

endmodule

// ===== src/cbe_horner_unit.sv =====
// shared multiply-shift-add unit: one horner step per cycle while run is set
// depends on cbe_pkg
module cbe_horner_unit import cbe_pkg::*; (
  input  logic                    clk_i,
  input  ctrl_pts_t               pts_i,
  input  horner_ctrl_t            ctl_i,
  input  logic [T_W-1:0]          t_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [COEF_W-1:0] px1, px2, py1, py2;
  logic signed [COEF_W-1:0] ca_x_d, cb_x_d, cc_x_d, ca_y_d, cb_y_d, cc_y_d;
  logic signed [COEF_W-1:0] ca_x_q, cb_x_q, cc_x_q, ca_y_q, cb_y_q, cc_y_q;
  logic signed [COEF_W-1:0] ca_sel;
  logic signed [ACC_W-1:0]  opa, addend, acc_d, acc_q;
  logic signed [T_W:0]      t_s;
  logic signed [ACC_W+T_W:0] prod;

  // coefficients: a = one - 3*p2 + 3*p1, b = 3*p2 - 6*p1, c = 3*p1
  always_comb begin
    px1 = signed'(COEF_W'(pts_i.x1));
    px2 = signed'(COEF_W'(pts_i.x2));
    py1 = {{(COEF_W-CTRL_Y_W){pts_i.y1[CTRL_Y_W-1]}}, pts_i.y1};
    py2 = {{(COEF_W-CTRL_Y_W){pts_i.y2[CTRL_Y_W-1]}}, pts_i.y2};
    ca_x_d = COEF_W'(signed'(COEF_W'(FX_ONE)) - 3 * px2 + 3 * px1);
    cb_x_d = COEF_W'(3 * px2 - 6 * px1);
    cc_x_d = COEF_W'(3 * px1);
    ca_y_d = COEF_W'(signed'(COEF_W'(FX_ONE)) - 3 * py2 + 3 * py1);
    cb_y_d = COEF_W'(3 * py2 - 6 * py1);
    cc_y_d = COEF_W'(3 * py1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ca_x_q <= ca_x_d;
      cb_x_q <= cb_x_d;
      cc_x_q <= cc_x_d;
      ca_y_q <= ca_y_d;
      cb_y_q <= cb_y_d;
      cc_y_q <= cc_y_d;
    end
  end

  always_comb begin
    ca_sel = ctl_i.sel_y ? ca_y_q : ca_x_q;
    opa    = acc_q;
    addend = '0;
    case (ctl_i.step)
      STEP_A: begin
        opa    = ACC_W'(ca_sel);
        addend = ACC_W'(ctl_i.sel_y ? cb_y_q : cb_x_q);
      end
      STEP_B: begin
        addend = ACC_W'(ctl_i.sel_y ? cc_y_q : cc_x_q);
      end
      default: ;
    endcase
    t_s  = signed'({1'b0, t_i});
    prod = opa * t_s;
    // arithmetic shift is floor rounding
    acc_d = ACC_W'(prod >>> FRAC_BITS) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== src/cbe_seq.sv =====
// bisection sequencer driving the shared horner unit
// depends on cbe_pkg
module cbe_seq import cbe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [PROG_W-1:0]       progress_i,
  input  ctrl_pts_t               pts_i,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic                    out_free_i,
  output logic                    in_ready_o,
  output horner_ctrl_t            hctl_o,
  output logic [T_W-1:0]          t_o,
  output logic                    done_o,
  output logic [OUT_W-1:0]        result_o
);

  seq_state_e   state_q, state_d;
  horner_step_e step_q, step_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [T_W-1:0]    lo_q, hi_q, t_q, x_q, x_clamp;
  logic [T_W-1:0]    lo_n, hi_n, mid_n;
  logic              bypass_q, bypass_now, accept;
  logic signed [ACC_W-1:0] diff;
  logic              d_pos, d_zero, last_iter;

  assign accept     = in_valid_i && in_ready_o;
  assign x_clamp    = (progress_i > FX_ONE) ? FX_ONE : progress_i;
  assign bypass_now = ((CTRL_Y_W'(pts_i.x1) == pts_i.y1) && (CTRL_Y_W'(pts_i.x2) == pts_i.y2))
                      || (x_clamp == '0) || (x_clamp == FX_ONE);

  // bisection decision from the finished x evaluation
  assign diff      = acc_i - signed'(ACC_W'(x_q));
  assign d_pos     = diff > 0;
  assign d_zero    = diff == '0;
  assign last_iter = iter_q == ITER_W'(MAX_ITERATIONS - 1);
  assign lo_n      = d_pos ? lo_q : t_q;
  assign hi_n      = d_pos ? t_q : hi_q;
  assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_A;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= x_clamp;
      bypass_q <= bypass_now;
      lo_q     <= '0;
      hi_q     <= FX_ONE;
      t_q      <= FX_ONE >> 1;
    end else if (state_q == ST_XCMP) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
      if (!(d_zero || last_iter)) t_q <= mid_n;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    iter_d       = iter_q;
    in_ready_o   = 1'b0;
    done_o       = 1'b0;
    hctl_o.load  = 1'b0;
    hctl_o.run   = 1'b0;
    hctl_o.sel_y = 1'b0;
    hctl_o.step  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        hctl_o.load = in_valid_i;
        if (in_valid_i) begin
          step_d  = STEP_A;
          iter_d  = '0;
          state_d = bypass_now ? ST_FINISH : ST_XEVAL;
        end
      end
      ST_XEVAL, ST_YEVAL: begin
        hctl_o.run   = 1'b1;
        hctl_o.sel_y = state_q == ST_YEVAL;
        unique case (step_q)
          STEP_A:  step_d = STEP_B;
          STEP_B:  step_d = STEP_C;
          default: begin
            step_d  = STEP_A;
            state_d = (state_q == ST_YEVAL) ? ST_FINISH : ST_XCMP;
          end
        endcase
      end
      ST_XCMP: begin
        if (d_zero || last_iter) begin
          state_d = ST_YEVAL;
        end else begin
          iter_d  = iter_q + 1'b1;
          state_d = ST_XEVAL;
        end
      end
      ST_FINISH: begin
        done_o = 1'b1;
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign t_o      = t_q;
  assign result_o = bypass_q ? OUT_W'(x_q) : sat_out(acc_i);

endmodule

// ===== src/cubic_bezier_easing_core.sv =====
// pass-through cases (linear curve, 0, 1) go from accept straight to the finish state
// otherwise n = 1..12 bisection steps over t, then the y evaluation
// each bisection step is three horner steps on the one shared multiplier plus a compare
// one transaction at a time: the next input is taken only once the result has gone to the output register
// reset (async, active low) restores the default control points and empties the output
// depends on cbe_pkg, cbe_if, cbe_cfg_regs, cbe_horner_unit, cbe_seq
`include "cubic_bezier_easing_core_assert.svh"
module cubic_bezier_easing_core import cbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  cbe_in_if.sink                in_if,
  cbe_out_if.source             out_if
);

  ctrl_pts_t               pts;
  horner_ctrl_t            hctl;
  logic [T_W-1:0]          t_val;
  logic signed [ACC_W-1:0] acc;
  logic                    seq_done, out_free;
  logic [OUT_W-1:0]        seq_result;

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_value_q;

  // control point registers, to be written only while idle; the block itself does not enforce this
  cbe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .pts_o   (pts)
  );

  // shared multiply-shift-add; coefficients latched when a transaction is taken
  cbe_horner_unit u_horner (
    .clk_i (clk_i),
    .pts_i (pts),
    .ctl_i (hctl),
    .t_i   (t_val),
    .acc_o (acc)
  );

  // sequencer: clamp, pass-through check, bisection over t, then the y evaluation
  cbe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .progress_i (in_if.progress),
    .pts_i      (pts),
    .acc_i      (acc),
    .out_free_i (out_free),
    .in_ready_o (in_if.ready),
    .hctl_o     (hctl),
    .t_o        (t_val),
    .done_o     (seq_done),
    .result_o   (seq_result)
  );

  // the result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= seq_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && out_free) out_value_q <= seq_result;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.eased_value = out_value_q;

  // a taken transaction keeps the core busy for at least the next cycle
  `CBE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_if.valid && in_if.ready, !in_if.ready, "input taken while previous transaction in flight")

  // delivered values stay inside the saturation range
  `CBE_ASSERT_NOW(a_out_range, clk_i, rst_ni, out_if.valid, ($signed(out_if.eased_value) >= -19'sd131072) && ($signed(out_if.eased_value) <= 19'sd196608), "eased value out of range")

  // a finished result waits for a free output slot and is not dropped
  `CBE_ASSERT_NEXT(a_result_held, clk_i, rst_ni, seq_done && !out_free, seq_done, "finished result lost while output stalled")

endmodule

// ===== tb/sv/cubic_bezier_easing_core_tb.sv =====
// self-checking testbench for cubic_bezier_easing_core: directed table, then random phases
// depends on cbe_pkg, cbe_if and the core; predicts each eased value in fixed point on its own
module cubic_bezier_easing_core_tb;
  import cbe_pkg::*;

  // cycles with no transaction on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 2000;
  // long receiver hold-off, so the core fills up and stalls its input
  localparam int HOLD_CYCLES     = 400;
  // random part: phases of fixed control points, items per phase
  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_PHASE      = 5;
  // settle time before a control point write and after the last result
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 60;
  localparam int MAX_REPORTS     = 200;

  localparam longint ONE_FX = longint'(1) << FRAC_BITS;
  localparam longint SAT_LO = longint'(OUT_MIN);
  localparam longint SAT_HI = longint'(OUT_MAX);

  typedef enum logic {
    ROW_ITEM,
    ROW_CTRL
  } row_kind_e;

  // one line of the directed table: either a progress value or a full set of control points
  typedef struct packed {
    row_kind_e               kind;
    logic [PROG_W-1:0]       prog;
    logic                    pinned;
    logic signed [OUT_W-1:0] want;
    ctrl_pts_t               pts;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  cbe_in_if  in_ch ();
  cbe_out_if out_ch ();

  cubic_bezier_easing_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // control points as the core holds them, only changed while the core is idle
  ctrl_pts_t ctrl_q;
  // eased values still owed by the core, oldest first
  logic signed [OUT_W-1:0] eased_q[$];
  logic signed [OUT_W-1:0] front_val;

  int  mismatches;
  int  quiet_cycles;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_req;
  int  stall_left;

  stim_row_t dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fixed-point product, floor rounding (arithmetic shift on a signed 64-bit value)
  function automatic longint fx_mul(longint a, longint t);
    return (a * t) >>> FRAC_BITS;
  endfunction

  // bezier polynomial at t by horner's rule, endpoints fixed at 0 and one
  function automatic longint curve_at(longint t, longint p1, longint p2);
    longint acc;
    acc = fx_mul(ONE_FX - 3 * p2 + 3 * p1, t) + 3 * p2 - 6 * p1;
    acc = fx_mul(acc, t) + 3 * p1;
    return fx_mul(acc, t);
  endfunction

  // eased value for one progress value under the current control points
  function automatic logic signed [OUT_W-1:0] eased_value_for(logic [PROG_W-1:0] prog);
    longint x, px1, py1, px2, py2, lo, hi, mid, d, y;
    x   = longint'(prog);
    px1 = longint'(ctrl_q.x1);
    py1 = longint'(ctrl_q.y1);
    px2 = longint'(ctrl_q.x2);
    py2 = longint'(ctrl_q.y2);
    // progress beyond one is clamped first
    if (x > ONE_FX) x = ONE_FX;
    // linear curve and both endpoints pass the progress through
    if ((px1 == py1 && px2 == py2) || x == 0 || x == ONE_FX) begin
      y = x;
    end else begin
      lo  = 0;
      hi  = ONE_FX;
      mid = 0;
      // bisect the curve parameter, stop on an exact hit; keep the last midpoint tried
      for (int i = 0; i < MAX_ITERATIONS; i++) begin
        mid = lo + ((hi - lo) >>> 1);
        d   = curve_at(mid, px1, px2) - x;
        if (d > 0) hi = mid;
        else lo = mid;
        if (d == 0) break;
      end
      y = curve_at(mid, py1, py2);
    end
    // saturate into the output range
    if (y < SAT_LO) y = SAT_LO;
    if (y > SAT_HI) y = SAT_HI;
    return OUT_W'(y);
  endfunction

  function automatic stim_row_t item_row(logic [PROG_W-1:0] prog, logic pinned,
                                         logic signed [OUT_W-1:0] want);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_ITEM;
    r.prog   = prog;
    r.pinned = pinned;
    r.want   = want;
    return r;
  endfunction

  function automatic stim_row_t ctrl_row(int x1, int y1, int x2, int y2);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_CTRL;
    r.pts.x1 = CTRL_X_W'(x1);
    r.pts.y1 = CTRL_Y_W'(y1);
    r.pts.x2 = CTRL_X_W'(x2);
    r.pts.y2 = CTRL_Y_W'(y2);
    return r;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // x control point: extremes, in range, now and then beyond one
  function automatic logic [CTRL_X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CTRL_X_W'(65536);
      2:       return CTRL_X_W'($urandom_range(0, 131071));
      default: return CTRL_X_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // y control point: extremes, in range, now and then any 19-bit pattern
  function automatic logic signed [CTRL_Y_W-1:0] rand_y();
    int v;
    v = int'($urandom_range(0, 327680)) - 131072;
    case ($urandom_range(0, 9))
      0:       return CTRL_Y_W'(-131072);
      1:       return CTRL_Y_W'(196608);
      2:       return CTRL_Y_W'($urandom);
      default: return CTRL_Y_W'(v);
    endcase
  endfunction

  // write all four control points once the core has drained
  task automatic apply_ctrl(input ctrl_pts_t pts);
    in_ch.valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    // the spare upper bits on x writes are random, the core keeps 17 bits
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_X1;
    cfg_wdata_i <= {2'($urandom), pts.x1};
    @(posedge clk_i);
    cfg_index_i <= CFG_Y1;
    cfg_wdata_i <= pts.y1;
    @(posedge clk_i);
    cfg_index_i <= CFG_X2;
    cfg_wdata_i <= {2'($urandom), pts.x2};
    @(posedge clk_i);
    cfg_index_i <= CFG_Y2;
    cfg_wdata_i <= pts.y2;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ctrl_q = pts;
  endtask

  // offer one progress value, record what it must produce once accepted
  // valid is left high on return so back-to-back transactions need no second assignment
  task automatic send_progress(input logic [PROG_W-1:0] prog, input logic pinned,
                               input logic signed [OUT_W-1:0] want);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.progress <= prog;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    eased_q.push_back(pinned ? want : eased_value_for(prog));
  endtask

  // receiver: random back-pressure, a steady stretch when stalls are off, one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!stalls_on || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (eased_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: eased_value expected none, got %0d", $time, out_ch.eased_value);
        end else begin
          front_val = eased_q.pop_front();
          if (out_ch.eased_value !== front_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: eased_value expected %0d, got %0d", $time, front_val,
                       out_ch.eased_value);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cubic_bezier_easing_core test failed");
        $finish;
      end
    end
  end

  initial begin
    ctrl_pts_t         pts;
    logic [PROG_W-1:0] prog;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_X1;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.progress = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_req       = 1'b0;
    ctrl_q.x1      = RST_X1;
    ctrl_q.y1      = RST_Y1;
    ctrl_q.x2      = RST_X2;
    ctrl_q.y2      = RST_Y2;

    // directed table; pinned rows carry a value that needs no arithmetic
    // reset control points: endpoints, clamp of the top value and of just past one
    dir_rows.push_back(item_row(17'd0, 1'b1, 19'sd0));
    dir_rows.push_back(item_row(17'd65536, 1'b1, 19'sd65536));
    dir_rows.push_back(item_row(17'd131071, 1'b1, 19'sd65536));
    dir_rows.push_back(item_row(17'd65537, 1'b1, 19'sd65536));
    dir_rows.push_back(item_row(17'd1, 1'b0, '0));
    dir_rows.push_back(item_row(17'd65535, 1'b0, '0));
    dir_rows.push_back(item_row(17'd32768, 1'b0, '0));
    dir_rows.push_back(item_row(17'h0aaaa, 1'b0, '0));
    dir_rows.push_back(item_row(17'h05555, 1'b0, '0));
    // linear curve passes progress through, clamped
    dir_rows.push_back(ctrl_row(0, 0, 65536, 65536));
    dir_rows.push_back(item_row(17'd12345, 1'b1, 19'sd12345));
    dir_rows.push_back(item_row(17'd70000, 1'b1, 19'sd65536));
    // y at the ends of its range, x swapped to its extremes
    dir_rows.push_back(ctrl_row(65536, -131072, 0, 196608));
    dir_rows.push_back(item_row(17'd20000, 1'b0, '0));
    dir_rows.push_back(item_row(17'd45000, 1'b0, '0));
    dir_rows.push_back(item_row(17'd1, 1'b0, '0));
    // control points beyond their range are used as they are
    dir_rows.push_back(ctrl_row(131071, 262143, 131071, -262144));
    dir_rows.push_back(item_row(17'd30000, 1'b0, '0));
    dir_rows.push_back(item_row(17'd65535, 1'b0, '0));
    dir_rows.push_back(item_row(17'd2, 1'b0, '0));
    // linear again with the points swapped
    dir_rows.push_back(ctrl_row(65536, 65536, 0, 0));
    dir_rows.push_back(item_row(17'd777, 1'b1, 19'sd777));
    // x curve symmetric about one half: exact hit on the first midpoint, y is t cubed
    dir_rows.push_back(ctrl_row(0, 0, 65536, 0));
    dir_rows.push_back(item_row(17'd32768, 1'b1, 19'sd8192));
    // y overshoots far above one, then far below zero
    dir_rows.push_back(ctrl_row(0, 262143, 16384, 262143));
    dir_rows.push_back(item_row(17'd32768, 1'b0, '0));
    dir_rows.push_back(ctrl_row(0, -262144, 16384, -262144));
    dir_rows.push_back(item_row(17'd32768, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CTRL) apply_ctrl(dir_rows[i].pts);
      else send_progress(dir_rows[i].prog, dir_rows[i].pinned, dir_rows[i].want);
    end

    // random phases, each with its own control points and idling pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pts.x1 = rand_x();
      pts.y1 = rand_y();
      pts.x2 = rand_x();
      pts.y2 = rand_y();
      case ($urandom_range(0, 7))
        0: begin
          // linear curve
          pts.y1 = CTRL_Y_W'(pts.x1);
          pts.y2 = CTRL_Y_W'(pts.x2);
        end
        1: begin
          pts.x1 = RST_X1;
          pts.y1 = RST_Y1;
          pts.x2 = RST_X2;
          pts.y2 = RST_Y2;
        end
        default: ;
      endcase
      apply_ctrl(pts);
      gaps_on   = (ph % 4 != 1) && (ph != HOLD_PHASE);
      stalls_on = (ph % 4 != 2);
      // sender keeps offering while the receiver holds off
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 19))
          0:       prog = '0;
          1:       prog = PROG_W'(65536);
          2:       prog = PROG_W'($urandom_range(65537, 131071));
          3:       prog = PROG_W'($urandom_range(1, 3));
          4:       prog = PROG_W'($urandom_range(65530, 65535));
          default: prog = PROG_W'($urandom_range(1, 65535));
        endcase
        send_progress(prog, 1'b0, '0);
      end
    end

    // drain: every expected value must arrive, then look for stray results
    in_ch.valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("cubic_bezier_easing_core test passed");
    end else begin
      $display("cubic_bezier_easing_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cbe_pkg.sv
src/cbe_if.sv
src/cbe_cfg_regs.sv
src/cbe_horner_unit.sv
src/cbe_seq.sv
src/cubic_bezier_easing_core.sv
tb/sv/cubic_bezier_easing_core_tb.sv
